FILE: src/lsb_stego_embed_extract_macros.svh
// ---------------------------------------------------------------------------
// lsb_stego_embed_extract_macros.svh
// Assertion macros used by the checker of the LSB stego block.
// ---------------------------------------------------------------------------
`ifndef LSB_STEGO_EMBED_EXTRACT_MACROS_SVH
`define LSB_STEGO_EMBED_EXTRACT_MACROS_SVH

// property on the block clock, switched off while reset is high
`define LSBSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// a signal keeps its value in the cycle after a condition
`define LSBSE_ASSERT_HOLD(label, cond, sig, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> $stable(sig)) else $error(msg);

`endif

FILE: src/lsbse_pkg.sv
// ---------------------------------------------------------------------------
// lsbse_pkg
// Types, codes and helpers shared by the LSB stego embed/extract block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsbse_pkg;

   localparam int BYTE_W  = 8;
   localparam int BUF_W   = 16;
   localparam int CNT_W   = 5;
   localparam int N_W     = 4;
   localparam int LEN_W   = 16;
   localparam int ST_W    = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_PAD  = 2'd1;
   localparam logic [ST_W-1:0] ST_DROP = 2'd2;

   localparam logic KIND_COVER = 1'b0;
   localparam logic KIND_MSG   = 1'b1;

   localparam logic OP_MESSAGE = 1'b0;
   localparam logic OP_COVER   = 1'b1;

   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BITS    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MSG_LEN = 2'd2;

   localparam logic [N_W-1:0] BITS_RESET = 4'd1;

   typedef enum logic [1:0] {
      CLS_EMBED_MSG,
      CLS_EMBED_COVER,
      CLS_EXTRACT_COVER
   } item_class_type;

   typedef struct packed {
      item_class_type     cls;
      logic [BYTE_W-1:0]  data;
   } queue_item_type;

   typedef struct packed {
      logic               full;
      logic               empty;
   } q_status_type;

   typedef struct packed {
      logic               mode;
      logic [N_W-1:0]     bits_per_byte;
      logic [LEN_W-1:0]   message_length;
   } cfg_type;

   // effective field width: zero acts as one, anything above eight as eight
   function automatic logic [N_W-1:0] width_n(input logic [N_W-1:0] bpb);
      logic [N_W-1:0] n;
      priority if (bpb == '0) begin
         n = 4'd1;
      end else if (bpb > 4'd8) begin
         n = 4'd8;
      end else begin
         n = bpb;
      end
      return n;
   endfunction

endpackage

FILE: src/lsbse_front.sv
// ---------------------------------------------------------------------------
// lsbse_front
// Input stage: takes request words, classifies them and feeds the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbse_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_mode,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [lsbse_pkg::BYTE_W-1:0]  req_data_byte,
   input  lsbse_pkg::q_status_type       q_status,
   output logic                          q_push,
   output lsbse_pkg::queue_item_type     q_item
);
   import lsbse_pkg::*;

   logic            valid_ff, valid_in;
   queue_item_type  item_ff;
   item_class_type  cls;
   logic            keep;
   logic            accept;

   // message words in extract mode carry nothing and are dropped here
   always_comb begin
      keep = 1'b1;
      cls  = CLS_EMBED_MSG;
      if (cfg_mode == MODE_EMBED) begin
         cls = (req_operation == OP_MESSAGE) ? CLS_EMBED_MSG : CLS_EMBED_COVER;
      end else begin
         cls  = CLS_EXTRACT_COVER;
         keep = (req_operation == OP_COVER);
      end
   end

   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_status.full;
   assign q_item    = item_ff;

   always_comb begin
      if (accept && keep) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cls  <= cls;
         item_ff.data <= req_data_byte;
      end
   end

endmodule

FILE: src/lsbse_queue.sv
// ---------------------------------------------------------------------------
// lsbse_queue
// Short register queue between the classifying front and the bit engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbse_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lsbse_pkg::queue_item_type  push_item,
   input  logic                       pop,
   output lsbse_pkg::queue_item_type  head,
   output lsbse_pkg::q_status_type    status
);
   import lsbse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QC_W  = $clog2(DEPTH + 1);

   queue_item_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] q;
      if (p == PTR_W'(DEPTH - 1)) begin
         q = '0;
      end else begin
         q = p + PTR_W'(1);
      end
      return q;
   endfunction

   assign status.full  = (count_ff == QC_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/lsbse_back.sv
// ---------------------------------------------------------------------------
// lsbse_back
// Bit engine: embeds or extracts bits per queued word, drives the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsbse_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lsbse_pkg::cfg_type            cfg,
   input  logic                          clear,
   input  lsbse_pkg::q_status_type       q_status,
   input  lsbse_pkg::queue_item_type     q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsbse_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_out_kind,
   output logic [lsbse_pkg::ST_W-1:0]    rsp_status,
   output logic                          rsp_last
);
   import lsbse_pkg::*;

   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  rec_ff, rec_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_kind_ff;
   logic [ST_W-1:0]   out_status_ff;
   logic              out_last_ff;

   logic              res_valid;
   logic [BYTE_W-1:0] res_byte;
   logic              res_kind;
   logic [ST_W-1:0]   res_status;
   logic              res_last;

   logic [N_W-1:0]    n;
   logic [CNT_W-1:0]  n_wide;
   logic [BYTE_W-1:0] mask;
   logic [BYTE_W-1:0] chunk;
   logic [BUF_W-1:0]  ext_base_buf;
   logic [CNT_W-1:0]  ext_base_cnt;
   logic [BUF_W-1:0]  ext_ins;
   logic [BUF_W-1:0]  ext_buf;
   logic [CNT_W-1:0]  ext_cnt;
   logic [LEN_W-1:0]  rec_next;
   logic              out_free;

   assign n      = width_n(cfg.bits_per_byte);
   assign n_wide = {1'b0, n};
   assign mask   = BYTE_W'((9'd1 << n) - 9'd1);
   assign chunk  = buf_ff[BUF_W-1 -: BYTE_W] >> (4'd8 - n);

   // extract: place the n low bits just under the valid ones, left aligned
   assign ext_base_buf = ((cnt_ff + n_wide) > 5'd16) ? '0 : buf_ff;
   assign ext_base_cnt = ((cnt_ff + n_wide) > 5'd16) ? '0 : cnt_ff;
   assign ext_ins      = ({8'h00, q_head.data & mask} << (5'd16 - n_wide)) >> ext_base_cnt;
   assign ext_buf      = ext_base_buf | ext_ins;
   assign ext_cnt      = ext_base_cnt + n_wide;
   assign rec_next     = rec_ff + LEN_W'(1);

   assign out_free = !out_valid_ff || !rsp_stall;
   assign q_pop    = !q_status.empty && out_free;

   always_comb begin
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      rec_in     = rec_ff;
      res_valid  = 1'b0;
      res_byte   = q_head.data;
      res_kind   = KIND_COVER;
      res_status = ST_OK;
      res_last   = 1'b0;
      unique case (q_head.cls)
         CLS_EMBED_MSG: begin
            if (cnt_ff > 5'd8) begin
               res_valid  = 1'b1;
               res_status = ST_DROP;
            end else begin
               buf_in = buf_ff | ({q_head.data, 8'h00} >> cnt_ff);
               cnt_in = cnt_ff + 5'd8;
            end
         end
         CLS_EMBED_COVER: begin
            res_valid  = 1'b1;
            res_byte   = (q_head.data & ~mask) | chunk;
            res_status = (cnt_ff < n_wide) ? ST_PAD : ST_OK;
            buf_in     = buf_ff << n;
            cnt_in     = (cnt_ff >= n_wide) ? (cnt_ff - n_wide) : '0;
         end
         CLS_EXTRACT_COVER: begin
            if (rec_ff < cfg.message_length) begin
               if (ext_cnt >= 5'd8) begin
                  res_valid = 1'b1;
                  res_byte  = ext_buf[BUF_W-1 -: BYTE_W];
                  res_kind  = KIND_MSG;
                  res_last  = (rec_next == cfg.message_length);
                  buf_in    = ext_buf << 8;
                  cnt_in    = ext_cnt - 5'd8;
                  rec_in    = rec_next;
               end else begin
                  buf_in = ext_buf;
                  cnt_in = ext_cnt;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_valid_in = q_pop ? res_valid : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         rec_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (clear) begin
            buf_ff <= '0;
            cnt_ff <= '0;
            rec_ff <= '0;
         end else if (q_pop) begin
            buf_ff <= buf_in;
            cnt_ff <= cnt_in;
            rec_ff <= rec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && res_valid) begin
         out_byte_ff   <= res_byte;
         out_kind_ff   <= res_kind;
         out_status_ff <= res_status;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_kind = out_kind_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last     = out_last_ff;

endmodule

FILE: src/lsb_stego_embed_extract.sv
// A result word is registered in the front, in the queue and at the output.
// Throughput: one word per cycle unless a side stalls; the bit engine handles a
// word each cycle it can pop, and the queue (QUEUE_DEPTH entries) lets either
// side stall alone. Reset (synchronous, active high) returns mode, bits_per_byte
// and message_length to 0, 1 and 0 and empties the bit buffer and queue.
// ---------------------------------------------------------------------------
// lsb_stego_embed_extract
// Streaming n-bit LSB steganography, embed and extract, with register port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_stego_embed_extract #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [lsbse_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsbse_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_out_kind,
   output logic [lsbse_pkg::ST_W-1:0]    rsp_status,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lsbse_pkg::ADDR_W-1:0]  paddr,
   input  logic [lsbse_pkg::DATA_W-1:0]  pwdata,
   output logic [lsbse_pkg::DATA_W-1:0]  prdata,
   output logic                          pready
);
   import lsbse_pkg::*;

   logic                  mode_ff;
   logic [N_W-1:0]        bits_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  cfg_wr;
   logic                  clear;
   cfg_type               cfg;

   logic                  q_push;
   logic                  q_pop;
   queue_item_type        q_item;
   queue_item_type        q_head;
   q_status_type          q_status;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];
   assign cfg_wr  = psel && penable && pwrite && pready;

   // a write to any real register restarts the stream
   assign clear = cfg_wr && ((reg_idx == REG_MODE) || (reg_idx == REG_BITS) ||
                             (reg_idx == REG_MSG_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EMBED;
         bits_ff <= BITS_RESET;
         len_ff  <= '0;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_MODE:    mode_ff <= pwdata[0];
            REG_BITS:    bits_ff <= pwdata[N_W-1:0];
            REG_MSG_LEN: len_ff  <= pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:    prdata = DATA_W'(mode_ff);
         REG_BITS:    prdata = DATA_W'(bits_ff);
         REG_MSG_LEN: prdata = DATA_W'(len_ff);
         default:     prdata = '0;
      endcase
   end

   assign cfg.mode           = mode_ff;
   assign cfg.bits_per_byte  = bits_ff;
   assign cfg.message_length = len_ff;

   lsbse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg_mode      (mode_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   lsbse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   lsbse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .clear        (clear),
      .q_status     (q_status),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: src/lsbse_checker.sv
// ---------------------------------------------------------------------------
// lsbse_checker
// Port-level checks on the result channel of the LSB stego block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lsb_stego_embed_extract_macros.svh"

module lsbse_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lsbse_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                          rsp_out_kind,
   input logic [lsbse_pkg::ST_W-1:0]    rsp_status,
   input logic                          rsp_last
);
   import lsbse_pkg::*;

   // a held result word keeps its byte
   `LSBSE_ASSERT_HOLD(a_rsp_byte_hold, rsp_valid && rsp_stall, rsp_out_byte, "rsp byte moved while stalled")

   // only recovered message bytes can close the message
   `LSBSE_ASSERT(a_last_on_msg, rsp_valid && rsp_last |-> rsp_out_kind == KIND_MSG, "last on a cover word")

   // padding and drop flags belong to the embed side
   `LSBSE_ASSERT(a_status_on_cover, rsp_valid && rsp_status != ST_OK |-> rsp_out_kind == KIND_COVER, "status flag on a message word")

   `LSBSE_ASSERT(a_status_code, rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_PAD || rsp_status == ST_DROP, "unknown status code")

endmodule

bind lsb_stego_embed_extract lsbse_checker u_checker (.*);
